// ----- design/fep_pkg.sv -----
// shared types, constants and helpers for the fisher exact p-value block
`timescale 1ns / 1ps
`default_nettype none
package fep_pkg;

    // count width of every table entry and register
    localparam int CW = 13;
    // working mantissa width of the float unit and its exponent width
    localparam int MW = 108;
    localparam int EW = 13;

    // configuration register indexes
    localparam logic [1:0] REG_TOTAL    = 2'd0;
    localparam logic [1:0] REG_POSITIVE = 2'd1;
    localparam logic [1:0] REG_ONE_SIDE = 2'd2;

    // double constants: one and the tie margin of the two-sided walk
    localparam logic [63:0] D_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] D_TINY = 64'h3C9C_D2B2_97D8_89BC;

    typedef enum logic [1:0] {
        FOP_DIV,
        FOP_MUL,
        FOP_ADD,
        FOP_SUB
    } t_fop;

    // request to the float unit: integer quotient or double operation
    typedef struct packed {
        logic          start;
        t_fop          op;
        logic [63:0]   a;
        logic [63:0]   b;
        logic [CW-1:0] ia;
        logic [CW-1:0] ib;
    } t_fpu_req;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic [63:0] result;
    } t_fpu_rsp;

    // unpacked double: subnormals keep a clear hidden bit at the least exponent
    typedef struct packed {
        logic                 s;
        logic signed [EW-1:0] e;
        logic [52:0]          m;
    } t_unp;

    function automatic t_unp fp_unpack(input logic [63:0] d);
        t_unp u;
        u.s = d[63];
        u.m = {(d[62:52] != 11'd0), d[51:0]};
        u.e = (d[62:52] == 11'd0) ? -13'sd1022
                                  : $signed({2'b00, d[62:52]}) - 13'sd1023;
        return u;
    endfunction

endpackage
`default_nettype wire

// ----- design/fep_fpu.sv -----
// shared iterative double unit: integer quotient, multiply, add, subtract
`timescale 1ns / 1ps
`default_nettype none
module fep_fpu (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  fep_pkg::t_fpu_req i_req,
    output fep_pkg::t_fpu_rsp o_rsp
);
    import fep_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE,
        F_DPRE,
        F_DIV,
        F_MUL,
        F_ALIGN,
        F_ADDOP,
        F_NORM,
        F_SUBN,
        F_PACK
    } t_fst;

    t_fst                 r_st;
    logic                 r_s;
    logic                 r_sb;
    logic signed [EW-1:0] r_e;
    logic [EW-1:0]        r_d;
    logic [MW-1:0]        r_m;
    logic [MW-1:0]        r_mb;
    logic [52:0]          r_ma53;
    logic [52:0]          r_mb53;
    logic [25:0]          r_ra;
    logic [25:0]          r_rb;
    logic [53:0]          r_q;
    logic [6:0]           r_cnt;
    logic                 r_done;
    logic [63:0]          r_res;

    t_unp          w_ua;
    t_unp          w_ub;
    t_unp          w_big;
    t_unp          w_sml;
    logic          w_bs;
    logic          w_swap;
    logic [105:0]  w_acc;
    logic          w_ge;
    logic [25:0]   w_rem;
    logic          w_inc;
    logic [53:0]   w_mr;
    logic [EW-1:0] w_e1;
    logic [EW-1:0] w_e2;
    logic [63:0]   w_pack;

    // shift right keeping lost bits jammed into the lowest bit
    function automatic logic [MW-1:0] rsh(input logic [MW-1:0] m);
        return {1'b0, m[MW-1:1]} | {{(MW-1){1'b0}}, m[0]};
    endfunction

    // operand unpacking and ordering by magnitude for add and subtract
    always_comb begin
        w_ua   = fp_unpack(i_req.a);
        w_ub   = fp_unpack(i_req.b);
        w_bs   = w_ub.s ^ (i_req.op == FOP_SUB);
        w_swap = i_req.b[62:0] > i_req.a[62:0];
        w_big  = w_swap ? {w_bs, w_ub.e, w_ub.m} : w_ua;
        w_sml  = w_swap ? w_ua : {w_bs, w_ub.e, w_ub.m};
    end

    // one step of shift-add multiply and of restoring division
    always_comb begin
        w_acc = {r_m[104:0], 1'b0} + {53'b0, (r_mb53[52] ? r_ma53 : 53'b0)};
        w_ge  = r_ra >= r_rb;
        w_rem = w_ge ? r_ra - r_rb : r_ra;
    end

    // round to nearest even and pack
    always_comb begin
        w_inc = r_m[52] & ((|r_m[51:0]) | r_m[53]);
        w_mr  = {1'b0, r_m[105:53]} + {53'b0, w_inc};
        w_e1  = EW'(r_e + 13'sd1023);
        w_e2  = EW'(r_e + 13'sd1024);
        if (r_m == '0) begin
            w_pack = {r_s, 63'b0};
        end else if (w_mr[53]) begin
            w_pack = {r_s, w_e2[10:0], 52'b0};
        end else begin
            w_pack = {r_s, (w_mr[52] ? w_e1[10:0] : 11'd0), w_mr[51:0]};
        end
    end

    // sequencer of the unit
    always_ff @(posedge i_clk) begin
        r_done <= i_rst_n && (r_st == F_PACK);
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            unique case (r_st)
                F_IDLE: begin
                    if (i_req.start) begin
                        unique case (i_req.op)
                            FOP_DIV: begin
                                r_s  <= 1'b0;
                                r_e  <= '0;
                                r_ra <= 26'(i_req.ia);
                                r_rb <= 26'(i_req.ib);
                                r_st <= F_DPRE;
                            end
                            FOP_MUL: begin
                                r_s    <= w_ua.s ^ w_ub.s;
                                r_e    <= w_ua.e + w_ub.e;
                                r_ma53 <= w_ua.m;
                                r_mb53 <= w_ub.m;
                                r_m    <= '0;
                                r_cnt  <= 7'd53;
                                if (w_ua.m == '0 || w_ub.m == '0) begin
                                    r_st <= F_PACK;
                                end else begin
                                    r_st <= F_MUL;
                                end
                            end
                            default: begin
                                r_s  <= w_big.s;
                                r_sb <= w_big.s ^ w_sml.s;
                                r_e  <= w_big.e;
                                r_d  <= EW'(w_big.e - w_sml.e);
                                r_m  <= {2'b0, w_big.m, 53'b0};
                                r_mb <= {2'b0, w_sml.m, 53'b0};
                                r_st <= F_ALIGN;
                            end
                        endcase
                    end
                end
                // bring the integer quotient into [1,2)
                F_DPRE: begin
                    if (r_ra < r_rb) begin
                        r_ra <= {r_ra[24:0], 1'b0};
                        r_e  <= r_e - 13'sd1;
                    end else if (r_ra >= {r_rb[24:0], 1'b0}) begin
                        r_rb <= {r_rb[24:0], 1'b0};
                        r_e  <= r_e + 13'sd1;
                    end else begin
                        r_q   <= '0;
                        r_cnt <= 7'd54;
                        r_st  <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_q   <= {r_q[52:0], w_ge};
                    r_ra  <= {w_rem[24:0], 1'b0};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_m  <= {2'b0, r_q[52:0], w_ge, 51'b0, (w_rem != '0)};
                        r_st <= F_NORM;
                    end
                end
                F_MUL: begin
                    r_mb53 <= {r_mb53[51:0], 1'b0};
                    r_cnt  <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_m  <= {1'b0, w_acc, 1'b0};
                        r_st <= F_NORM;
                    end else begin
                        r_m <= {2'b0, w_acc};
                    end
                end
                // line up the smaller operand
                F_ALIGN: begin
                    if (r_d == '0) begin
                        r_st <= F_ADDOP;
                    end else if (r_d >= EW'(110)) begin
                        r_mb <= {{(MW-1){1'b0}}, (r_mb != '0)};
                        r_d  <= '0;
                    end else begin
                        r_mb <= rsh(r_mb);
                        r_d  <= r_d - EW'(1);
                    end
                end
                F_ADDOP: begin
                    if (r_sb) begin
                        r_m <= r_m - r_mb;
                        if (r_m == r_mb) begin
                            r_s <= 1'b0;
                        end
                    end else begin
                        r_m <= r_m + r_mb;
                    end
                    r_st <= F_NORM;
                end
                // leading one to the hidden bit position
                F_NORM: begin
                    if (r_m == '0) begin
                        r_st <= F_PACK;
                    end else if (r_m[MW-1:MW-2] != 2'b00) begin
                        r_m <= rsh(r_m);
                        r_e <= r_e + 13'sd1;
                    end else if (!r_m[105]) begin
                        r_m <= {r_m[MW-2:0], 1'b0};
                        r_e <= r_e - 13'sd1;
                    end else begin
                        r_st <= F_SUBN;
                    end
                end
                // denormalise below the least exponent
                F_SUBN: begin
                    if (r_e < -13'sd1022) begin
                        r_m <= rsh(r_m);
                        r_e <= r_e + 13'sd1;
                    end else begin
                        r_st <= F_PACK;
                    end
                end
                F_PACK: begin
                    r_res  <= w_pack;
                    r_st   <= F_IDLE;
                end
                default: r_st <= F_IDLE;
            endcase
        end
    end

    assign o_rsp.idle   = (r_st == F_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule
`default_nettype wire

// ----- design/fisher_exact_pvalue.sv -----
// fisher exact test p-value block for a 2x2 table, top level
//
// configuration: write total_count (0), positive_count (1) and one_sided (2)
// on the plain write port while the block is idle; counts saturate at
// MAX_COUNT, other indexes are ignored.
// input stream: one transfer per table, support and positive_support.
// output stream: one transfer per table with the p-value, the minimum
// achievable p-value and the bad input flag.
// every factor is an integer quotient and a multiply on one shared iterative
// double unit; a cell costs 4*support such operations and one or two sums,
// times the cells summed, plus 2*min(support, positives) for the minimum.
// the input is not ready while a table is being worked on.
// a finished result waits in the output register, so the next table may be
// taken while the receiver stalls; the block holds then only at the end of
// the next table until that result is taken.
// reset clears the registers to total 1, positives 0, two-sided, and empties
// the output register.
`timescale 1ns / 1ps
`default_nettype none
module fisher_exact_pvalue #(
    parameter int unsigned MAX_COUNT = 4096
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_addr,
    input  wire  [12:0]  i_cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // support [12:0], positive_support [25:13], zero [31:26]
    input  wire  [31:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // p_value [63:0], min_p_value [127:64]
    output logic [127:0] m_axis_tdata,
    // bad_input [0]
    output logic [0:0]   m_axis_tuser
);
    import fep_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CINIT,
        S_CCHK,
        S_D1,
        S_M1,
        S_D2,
        S_M2,
        S_CEND,
        S_SUB,
        S_ADD,
        S_NEXT,
        S_MCHK,
        S_MD,
        S_MM,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        W_P0,
        W_LOW,
        W_HIGH,
        W_ONE
    } t_walk;

    t_state        r_st;
    t_walk         r_walk;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_n1;
    logic          r_one;
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_a;
    logic [CW-1:0] r_n1e;
    logic [CW-1:0] r_n0;
    logic [CW-1:0] r_top;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_b;
    logic          r_ph;
    logic          r_bad;
    logic [63:0]   r_pc;
    logic [63:0]   r_p;
    logic [63:0]   r_p0;
    logic [63:0]   r_minp;
    t_fpu_req      r_req;
    logic          r_ov;
    logic [127:0]  r_od;
    logic          r_ou;

    t_fpu_rsp      w_rsp;
    logic [CW-1:0] w_inx;
    logic [CW-1:0] w_ina;
    logic [CW-1:0] w_n1e;
    logic [CW-1:0] w_top;
    logic [CW-1:0] w_m;
    logic [CW-1:0] w_f1a;
    logic [CW-1:0] w_f1b;
    logic [CW-1:0] w_f2a;
    logic [CW-1:0] w_f2b;
    logic [CW-1:0] w_cfg_sat;
    logic          w_brk;

    fep_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // table limits at the input transfer
    always_comb begin
        w_inx = s_axis_tdata[12:0];
        w_ina = s_axis_tdata[25:13];
        w_n1e = (r_n1 > r_n) ? r_n : r_n1;
        w_top = (w_inx < w_n1e) ? w_inx : w_n1e;
        w_cfg_sat = (21'(i_cfg_wdata) > 21'(MAX_COUNT)) ? CW'(MAX_COUNT) : i_cfg_wdata;
    end

    // factor operands of the cell probability
    always_comb begin
        w_m = r_k + r_i;
        if (!r_ph) begin
            w_f1a = r_n1e - r_i;
            w_f1b = r_k - r_i;
            w_f2a = r_x - r_i;
            w_f2b = r_n - r_i;
        end else begin
            w_f1a = r_n0 - r_i;
            w_f1b = r_b - r_i;
            w_f2a = r_x - w_m;
            w_f2b = r_n - w_m;
        end
        w_brk = !w_rsp.result[63] && (w_rsp.result[62:0] > D_TINY[62:0]);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= CW'(1);
            r_n1  <= '0;
            r_one <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TOTAL:    r_n   <= w_cfg_sat;
                REG_POSITIVE: r_n1  <= w_cfg_sat;
                REG_ONE_SIDE: r_one <= i_cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // sequencer over cells, tail walks and the minimum product
    always_ff @(posedge i_clk) begin
        logic n_start;
        n_start = 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && m_axis_tready && r_st != S_DONE) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x    <= w_inx;
                        r_a    <= w_ina;
                        r_n1e  <= w_n1e;
                        r_n0   <= r_n - w_n1e;
                        r_top  <= w_top;
                        r_k    <= w_ina;
                        r_walk <= W_P0;
                        r_bad  <= (w_inx > r_n) || (w_ina > w_top);
                        if ((w_inx > r_n) || (w_ina > w_top)) begin
                            r_st <= S_DONE;
                        end else begin
                            r_st <= S_CINIT;
                        end
                    end
                end
                S_CINIT: begin
                    r_b  <= r_x - r_k;
                    r_i  <= '0;
                    r_ph <= 1'b0;
                    if ((r_x - r_k) > r_n0) begin
                        r_pc <= '0;
                        r_st <= S_CEND;
                    end else begin
                        r_pc <= D_ONE;
                        r_st <= S_CCHK;
                    end
                end
                S_CCHK: begin
                    if (!r_ph && r_i == r_k) begin
                        r_ph <= 1'b1;
                        r_i  <= '0;
                    end else if (r_ph && r_i == r_b) begin
                        r_st <= S_CEND;
                    end else begin
                        n_start      = 1'b1;
                        r_req.op    <= FOP_DIV;
                        r_req.ia    <= w_f1a;
                        r_req.ib    <= w_f1b;
                        r_st        <= S_D1;
                    end
                end
                S_D1, S_D2: begin
                    if (w_rsp.done) begin
                        n_start      = 1'b1;
                        r_req.op    <= FOP_MUL;
                        r_req.a     <= r_pc;
                        r_req.b     <= w_rsp.result;
                        r_st        <= (r_st == S_D1) ? S_M1 : S_M2;
                    end
                end
                S_M1: begin
                    if (w_rsp.done) begin
                        r_pc        <= w_rsp.result;
                        n_start      = 1'b1;
                        r_req.op    <= FOP_DIV;
                        r_req.ia    <= w_f2a;
                        r_req.ib    <= w_f2b;
                        r_st        <= S_D2;
                    end
                end
                S_M2: begin
                    if (w_rsp.done) begin
                        r_pc <= w_rsp.result;
                        r_i  <= r_i + CW'(1);
                        r_st <= S_CCHK;
                    end
                end
                // cell finished: observed cell, summed cell or tie check
                S_CEND: begin
                    unique case (r_walk)
                        W_P0: begin
                            r_p0 <= r_pc;
                            r_p  <= r_pc;
                            r_walk <= r_one ? W_ONE : W_LOW;
                            r_k    <= r_one ? r_a + CW'(1) : '0;
                            r_st   <= S_NEXT;
                        end
                        W_ONE: begin
                            n_start      = 1'b1;
                            r_req.op    <= FOP_ADD;
                            r_req.a     <= r_p;
                            r_req.b     <= r_pc;
                            r_st        <= S_ADD;
                        end
                        default: begin
                            n_start      = 1'b1;
                            r_req.op    <= FOP_SUB;
                            r_req.a     <= r_pc;
                            r_req.b     <= r_p0;
                            r_st        <= S_SUB;
                        end
                    endcase
                end
                S_SUB: begin
                    if (w_rsp.done) begin
                        if (w_brk) begin
                            if (r_walk == W_LOW) begin
                                r_walk <= W_HIGH;
                                r_k    <= r_top;
                                r_st   <= S_NEXT;
                            end else begin
                                r_minp <= D_ONE;
                                r_i    <= '0;
                                r_st   <= S_MCHK;
                            end
                        end else begin
                            n_start      = 1'b1;
                            r_req.op    <= FOP_ADD;
                            r_req.a     <= r_p;
                            r_req.b     <= r_pc;
                            r_st        <= S_ADD;
                        end
                    end
                end
                S_ADD: begin
                    if (w_rsp.done) begin
                        r_p  <= w_rsp.result;
                        r_k  <= (r_walk == W_HIGH) ? r_k - CW'(1) : r_k + CW'(1);
                        r_st <= S_NEXT;
                    end
                end
                // next cell of the current walk, or the next walk
                S_NEXT: begin
                    priority if (r_walk == W_LOW && r_k < r_a) begin
                        r_st <= S_CINIT;
                    end else if (r_walk == W_LOW) begin
                        r_walk <= W_HIGH;
                        r_k    <= r_top;
                    end else if (r_walk == W_HIGH && r_k > r_a) begin
                        r_st <= S_CINIT;
                    end else if (r_walk == W_ONE && r_k <= r_top) begin
                        r_st <= S_CINIT;
                    end else begin
                        r_minp <= D_ONE;
                        r_i    <= '0;
                        r_st   <= S_MCHK;
                    end
                end
                // minimum achievable p-value product
                S_MCHK: begin
                    if (r_i == r_top) begin
                        r_st <= S_DONE;
                    end else begin
                        n_start      = 1'b1;
                        r_req.op    <= FOP_DIV;
                        r_req.ia    <= r_n1e - r_i;
                        r_req.ib    <= r_n - r_i;
                        r_st        <= S_MD;
                    end
                end
                S_MD: begin
                    if (w_rsp.done) begin
                        n_start      = 1'b1;
                        r_req.op    <= FOP_MUL;
                        r_req.a     <= r_minp;
                        r_req.b     <= w_rsp.result;
                        r_st        <= S_MM;
                    end
                end
                S_MM: begin
                    if (w_rsp.done) begin
                        r_minp <= w_rsp.result;
                        r_i    <= r_i + CW'(1);
                        r_st   <= S_MCHK;
                    end
                end
                // hand the result to the output register
                S_DONE: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov <= 1'b1;
                        r_ou <= r_bad;
                        r_od <= r_bad ? {D_ONE, D_ONE} : {r_minp, r_p};
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
        r_req.start <= n_start;
    end

    assign s_axis_tready   = (r_st == S_IDLE);
    assign m_axis_tvalid   = r_ov;
    assign m_axis_tdata    = r_od;
    assign m_axis_tuser[0] = r_ou;

`ifndef ASSERT_OFF
    // the float unit is only started when it is free
    a_fpu_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |-> w_rsp.idle)
        else $error("float unit started while busy");

    // a result from the unit only arrives while the sequencer waits for one
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_st == S_D1 || r_st == S_D2 || r_st == S_M1 ||
                        r_st == S_M2 || r_st == S_SUB || r_st == S_ADD ||
                        r_st == S_MD || r_st == S_MM))
        else $error("unexpected float unit result");

    // a bad table gives one for both values
    a_bad_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == {D_ONE, D_ONE}))
        else $error("bad input result not one");

    // probabilities are never negative
    a_non_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[63] && !m_axis_tdata[127]))
        else $error("negative probability");
`endif

endmodule
`default_nettype wire
